// ===== src/hbad_pkg.sv =====
// ----------------------------------------------------------------------------
// hbad_pkg
// Shared target codes, address map bounds and decode structures for the
// handheld bus address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbad_pkg;

  // Target codes
  localparam logic [3:0] T_INTERNAL = 4'd0;
  localparam logic [3:0] T_BOOT     = 4'd1;
  localparam logic [3:0] T_CROM     = 4'd2;
  localparam logic [3:0] T_VRAM     = 4'd3;
  localparam logic [3:0] T_CRAM     = 4'd4;
  localparam logic [3:0] T_OAM      = 4'd5;
  localparam logic [3:0] T_JOYPAD   = 4'd6;
  localparam logic [3:0] T_SERIAL   = 4'd7;
  localparam logic [3:0] T_TIMER    = 4'd8;
  localparam logic [3:0] T_INT      = 4'd9;
  localparam logic [3:0] T_AUDIO    = 4'd10;
  localparam logic [3:0] T_GFX      = 4'd11;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MISSING  = 1'b0;
  localparam logic CFG_UNMAPPED = 1'b1;

  // Memory map bounds (inclusive upper ends unless noted)
  localparam logic [15:0] BOOT_LIMIT  = 16'h0100;  // exclusive
  localparam logic [15:0] CROM_END    = 16'h7FFF;
  localparam logic [15:0] VRAM_END    = 16'h9FFF;
  localparam logic [15:0] CRAM_END    = 16'hBFFF;
  localparam logic [15:0] WRAM_END    = 16'hFDFF;
  localparam logic [15:0] OAM_END     = 16'hFE9F;
  localparam logic [15:0] PROHIB_END  = 16'hFEFF;
  localparam logic [15:0] IO_END      = 16'hFF7F;
  localparam logic [15:0] IO_SLOT_END = 16'hFF77;
  localparam logic [15:0] BOOT_REG    = 16'hFF50;
  localparam logic [15:0] HRAM_END    = 16'hFFFE;

  localparam logic [7:0] PROHIB_DATA  = 8'h42;
  localparam logic [7:0] DMA_OAM_DATA = 8'hFF;
  localparam logic [7:0] IE_OFFSET    = 8'hFF;

  // High RAM is fixed at 128 bytes
  localparam int HRAM_AW = 7;

  typedef struct packed {
    logic wram_re;
    logic wram_we;
    logic hram_re;
    logic hram_we;
  } mem_req_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [14:0] offset;
    logic        write_strobe;
    logic        read_from_target;
    logic [7:0]  read_data;
    logic        from_mem;
    mem_req_t    mem;
    logic        boot_we;
  } dec_t;

  function automatic logic [3:0] io_slot_target(input logic [7:0] lo);
    logic [3:0] t;
    t = T_INTERNAL;
    if (lo == 8'h00) t = T_JOYPAD;
    else if (lo inside {8'h01, 8'h02}) t = T_SERIAL;
    else if (lo inside {[8'h04:8'h07]}) t = T_TIMER;
    else if (lo == 8'h0F) t = T_INT;
    else if (lo inside {[8'h10:8'h14], [8'h16:8'h1E], [8'h20:8'h26], [8'h30:8'h3F]})
      t = T_AUDIO;
    else if (lo inside {[8'h40:8'h4B]}) t = T_GFX;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/hbad_decode.sv =====
// ----------------------------------------------------------------------------
// hbad_decode
// Address map decode of one bus transaction into target, offset, internal
// read data and memory/flag update requests.
// ----------------------------------------------------------------------------
`default_nettype none

module hbad_decode import hbad_pkg::*; (
  input  wire logic        cmd_i,
  input  wire logic [15:0] address_i,
  input  wire logic        dma_active_i,
  input  wire logic        boot_on_i,
  input  wire logic [7:0]  missing_val_i,
  input  wire logic [7:0]  unmapped_val_i,
  output dec_t             dec_o
);

  logic [15:0] a;
  logic [3:0]  slot;

  assign a    = address_i;
  assign slot = io_slot_target(a[7:0]);

  always_comb begin
    dec_o = '0;
    if (cmd_i == CMD_READ) begin
      if (a < BOOT_LIMIT && boot_on_i) begin
        dec_o.target = T_BOOT;
        dec_o.offset = {7'd0, a[7:0]};
      end else if (a <= CROM_END) begin
        dec_o.target = T_CROM;
        dec_o.offset = a[14:0];
      end else if (a <= VRAM_END) begin
        dec_o.target = T_VRAM;
        dec_o.offset = {2'd0, a[12:0]};
      end else if (a <= CRAM_END) begin
        dec_o.target = T_CRAM;
        dec_o.offset = {2'd0, a[12:0]};
      end else if (a <= WRAM_END) begin
        dec_o.mem.wram_re = 1'b1;
        dec_o.from_mem    = 1'b1;
      end else if (a <= OAM_END) begin
        if (dma_active_i) begin
          dec_o.read_data = DMA_OAM_DATA;
        end else begin
          dec_o.target = T_OAM;
          dec_o.offset = {7'd0, a[7:0]};
        end
      end else if (a <= PROHIB_END) begin
        dec_o.read_data = PROHIB_DATA;
      end else if (a <= IO_END) begin
        if (a == BOOT_REG) begin
          dec_o.read_data = {7'd0, ~boot_on_i};
        end else if (a <= IO_SLOT_END) begin
          if (slot == T_INTERNAL) begin
            dec_o.read_data = missing_val_i;
          end else begin
            dec_o.target = slot;
            dec_o.offset = {7'd0, a[7:0]};
          end
        end else begin
          dec_o.read_data = unmapped_val_i;
        end
      end else if (a <= HRAM_END) begin
        dec_o.mem.hram_re = 1'b1;
        dec_o.from_mem    = 1'b1;
      end else begin
        dec_o.target = T_INT;
        dec_o.offset = {7'd0, IE_OFFSET};
      end
    end else if (!dma_active_i) begin
      if (a <= CROM_END) begin
        dec_o.target = T_CROM;
        dec_o.offset = a[14:0];
      end else if (a <= VRAM_END) begin
        dec_o.target = T_VRAM;
        dec_o.offset = {2'd0, a[12:0]};
      end else if (a <= CRAM_END) begin
        dec_o.target = T_CRAM;
        dec_o.offset = {2'd0, a[12:0]};
      end else if (a <= WRAM_END) begin
        dec_o.mem.wram_we = 1'b1;
      end else if (a <= OAM_END) begin
        dec_o.target = T_OAM;
        dec_o.offset = {7'd0, a[7:0]};
      end else if (a <= PROHIB_END) begin
        dec_o.target = T_INTERNAL;  // drop
      end else if (a <= IO_END) begin
        if (a == BOOT_REG) begin
          dec_o.boot_we = 1'b1;
        end else if (a <= IO_SLOT_END && slot != T_INTERNAL) begin
          dec_o.target = slot;
          dec_o.offset = {7'd0, a[7:0]};
        end
      end else if (a <= HRAM_END) begin
        dec_o.mem.hram_we = 1'b1;
      end else begin
        dec_o.target = T_INT;
        dec_o.offset = {7'd0, IE_OFFSET};
      end
    end
    dec_o.write_strobe     = (cmd_i == CMD_WRITE) && (dec_o.target != T_INTERNAL);
    dec_o.read_from_target = (cmd_i == CMD_READ) && (dec_o.target != T_INTERNAL);
  end

endmodule

`default_nettype wire

// ===== src/hbad_mem.sv =====
// ----------------------------------------------------------------------------
// hbad_mem
// Work RAM and high RAM, single port each, with one shared registered read
// port. Read data holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module hbad_mem import hbad_pkg::*; #(
  parameter int WORK_RAM_BYTES = 8192
) (
  input  wire logic                              clk_i,
  input  wire mem_req_t                          req_i,
  input  wire logic [$clog2(WORK_RAM_BYTES)-1:0] wram_idx_i,
  input  wire logic [HRAM_AW-1:0]                hram_idx_i,
  input  wire logic [7:0]                        wdata_i,
  output logic [7:0]                             rdata_o
);

  logic [7:0] wram [WORK_RAM_BYTES];
  logic [7:0] hram [2**HRAM_AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wram_we) begin
      wram[wram_idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.hram_we) begin
      hram[hram_idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wram_re) begin
      rdata_q <= wram[wram_idx_i];
    end else if (req_i.hram_re) begin
      rdata_q <= hram[hram_idx_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/handheld_bus_address_decoder_core.sv =====
// ----------------------------------------------------------------------------
// handheld_bus_address_decoder_core
// Byte-wide memory map decoder with internal work RAM, high RAM and the
// boot overlay flag.
// ----------------------------------------------------------------------------
// Each input transaction is one bus read or write. The block decodes the
// address in the cycle it accepts the transaction, issues any work RAM or
// high RAM access at that edge, and when the decode stage advances merges
// the registered RAM read data into the result, which then lands in an
// output register. With the output side ready the block takes one
// transaction every cycle, set by the single RAM port that every access
// uses at its accept edge. A stalled result holds the decode stage and,
// through it, the input. Writes made without DMA active update RAM and
// the overlay flag at their accept edge, so a later read always sees
// them. The RAMs come up undefined and must be written before they are
// read. Configuration writes are accepted at any time and are expected
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module handheld_bus_address_decoder_core import hbad_pkg::*; #(
  parameter int WORK_RAM_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // input transaction channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic        dma_active_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       target_o,
  output logic [14:0]      target_offset_o,
  output logic             write_strobe_o,
  output logic             read_from_target_o,
  output logic [7:0]       read_data_o
);

  localparam int WRAM_AW = $clog2(WORK_RAM_BYTES);

  logic       boot_on_q, boot_on_d;
  logic [7:0] missing_q, unmapped_q;

  dec_t       dec;
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  logic       accept, s1_adv, out_free;
  logic       s1_valid_q, s1_valid_d;
  dec_t       s1_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] s1_rdata;

  // Configuration registers: always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      missing_q  <= 8'hFF;
      unmapped_q <= 8'hFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MISSING:  missing_q  <= cfg_data_i;
        CFG_UNMAPPED: unmapped_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode the transaction as presented.
  hbad_decode u_decode (
    .cmd_i          (cmd_i),
    .address_i      (address_i),
    .dma_active_i   (dma_active_i),
    .boot_on_i      (boot_on_q),
    .missing_val_i  (missing_q),
    .unmapped_val_i (unmapped_q),
    .dec_o          (dec)
  );

  // Handshake: advance decode stage when the output register frees up.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Issue RAM accesses only for accepted transactions.
  assign mem_req = accept ? dec.mem : '0;

  hbad_mem #(
    .WORK_RAM_BYTES (WORK_RAM_BYTES)
  ) u_mem (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .wram_idx_i (address_i[WRAM_AW-1:0]),
    .hram_idx_i (address_i[HRAM_AW-1:0]),
    .wdata_i    (write_data_i),
    .rdata_o    (mem_rdata)
  );

  // Boot overlay flag: on out of reset; each write turns it on for zero data, off otherwise.
  assign boot_on_d = (accept && dec.boot_we) ? (write_data_i == 8'd0) : boot_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_on_q <= 1'b1;
    end else begin
      boot_on_q <= boot_on_d;
    end
  end

  // Decode stage valid and payload.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= dec;
    end
  end

  // Merge RAM read data; the read register holds while the stage stalls.
  assign s1_rdata = s1_q.from_mem ? mem_rdata : s1_q.read_data;

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      target_o           <= s1_q.target;
      target_offset_o    <= s1_q.offset;
      write_strobe_o     <= s1_q.write_strobe;
      read_from_target_o <= s1_q.read_from_target;
      read_data_o        <= s1_rdata;
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions
  a_no_dual_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_strobe_o && read_from_target_o))
    else $error("result both forwards a write and requests target read data");

  a_target_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_from_target_o || write_strobe_o)) |-> (read_data_o == 8'd0))
    else $error("internal read data present on a forwarded transaction");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while decode stage is stalled");

  a_ram_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({mem_req.wram_re, mem_req.wram_we, mem_req.hram_re, mem_req.hram_we}) <= 1)
    else $error("more than one RAM access issued in one cycle");

endmodule

`default_nettype wire
